// ===== hdl/circle_packing_radius_defines.svh =====
// Assertion shorthands for the checker file (cpr_checker.sv).
`ifndef CIRCLE_PACKING_RADIUS_DEFINES_SVH
`define CIRCLE_PACKING_RADIUS_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define CPR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define CPR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/cpr_pkg.sv =====
package cpr_pkg;

  localparam int COORD_W          = 10;
  localparam int COORD_WIDE_W     = 16;
  localparam int MAXR_W           = 10;
  localparam int RADIUS_W         = 11;
  localparam int RADIUS_LIMIT     = 1023;
  localparam logic [MAXR_W-1:0] MAX_RADIUS_RESET = 10'd150;

  typedef struct packed {
    logic [COORD_W-1:0] center_x;
    logic [COORD_W-1:0] center_y;
  } in_item_t;

  typedef struct packed {
    logic signed [RADIUS_W-1:0] radius;
    logic                       store_full;
  } out_item_t;

endpackage

// ===== hdl/cpr_isqrt.sv =====
// Pipelined integer square root, one root bit resolved per stage.
// Accepts one value per cycle; each value passes an input register and then the stage registers before out_valid.
module cpr_isqrt #(
  parameter int RB    = 11,
  parameter int TAG_W = 11
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [2*RB-1:0]   in_value,
  input  logic [TAG_W-1:0]  in_tag,
  output logic              out_valid,
  output logic [RB-1:0]     out_root,
  output logic [TAG_W-1:0]  out_tag,
  output logic              pipe_busy
);

  logic [2*RB-1:0]  rem_r  [RB+1];
  logic [RB-1:0]    root_r [RB+1];
  logic [TAG_W-1:0] tag_r  [RB+1];
  logic [RB:0]      vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0]  <= in_value;
    root_r[0] <= '0;
    tag_r[0]  <= in_tag;
  end

  for (genvar j = 0; j < RB; j++) begin : g_stage
    localparam int K = RB - 1 - j;
    logic [2*RB-1:0] inc;

    // (2*root + 2^K) * 2^K; root only has bits above K here
    assign inc = ({{RB{1'b0}}, root_r[j]} << (K + 1)) | ((2*RB)'(1) << (2 * K));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j+1] <= 1'b0;
      end else begin
        vld_r[j+1] <= vld_r[j];
      end
    end

    always_ff @(posedge clk) begin
      tag_r[j+1] <= tag_r[j];
      if (rem_r[j] >= inc) begin
        rem_r[j+1]  <= rem_r[j] - inc;
        root_r[j+1] <= root_r[j] | (RB'(1) << K);
      end else begin
        rem_r[j+1]  <= rem_r[j];
        root_r[j+1] <= root_r[j];
      end
    end
  end

  assign out_valid = vld_r[RB];
  assign out_root  = root_r[RB];
  assign out_tag   = tag_r[RB];
  assign pipe_busy = |vld_r;

endmodule

// ===== hdl/circle_packing_radius.sv =====
// Greedy circle packing radius chooser. Pulse start with a centre while busy is low; the
// result appears on out_data for exactly one cycle with out_valid high and cannot be
// stalled, so the receiver must take it then. The result strobe comes when the block is
// idle again, so a new start can already be accepted alongside it. The time an item takes
// is set by the scan: one read of the circle memory per stored circle, streamed through
// subtract and square registers and a COORD_BITS+1 stage square-root pipeline. max_radius
// may be written through cfg_* whenever busy is low (cfg_ready).
// Once CAPACITY circles are stored, results still come out but store_full is set and the
// circle is dropped. Only reset empties the store.
module circle_packing_radius
  import cpr_pkg::*;
#(
  parameter int CAPACITY   = 16,
  parameter int COORD_BITS = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_item_t          in_data,
  output logic              out_valid,
  output out_item_t         out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [MAXR_W-1:0] cfg_data
);

  localparam int C  = COORD_BITS;
  localparam int RB = C + 1;
  localparam int FW = ((RB > RADIUS_W) ? RB : RADIUS_W) + 2;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int MW = 2 * C + RADIUS_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  localparam logic signed [FW-1:0] LIM_HI = FW'(RADIUS_LIMIT);
  localparam logic signed [FW-1:0] LIM_LO = -LIM_HI;

  logic                       state_r, state_nxt;
  logic [CW-1:0]              count_r;
  logic [CW-1:0]              issue_r;
  logic [MAXR_W-1:0]          max_radius_r;
  logic [C-1:0]               cx_r, cy_r;
  logic signed [FW-1:0]       best_r;
  logic                       out_valid_r;
  out_item_t                  out_data_r;

  logic [MW-1:0]              mem [CAPACITY];
  logic [MW-1:0]              rd_data_r;
  logic                       s1_vld_r, s2_vld_r, s3_vld_r;
  logic [C-1:0]               dx_r, dy_r;
  logic [RADIUS_W-1:0]        rad2_r, rad3_r;
  logic [2*C-1:0]             sqx_r, sqy_r;

  logic                       accept, rd_en, done, full, sq_busy, sq_vld;
  logic [COORD_WIDE_W-1:0]    in_x_wide, in_y_wide;
  logic [C-1:0]               in_x, in_y, rd_x, rd_y;
  logic [RADIUS_W-1:0]        rd_rad, sq_tag;
  logic [2*RB-1:0]            dist_sq;
  logic [RB-1:0]              sq_root;
  logic signed [FW-1:0]       fit, best_clamped;
  logic signed [RADIUS_W-1:0] radius_out;

  assign accept = start && (state_r == ST_IDLE);
  assign rd_en  = (state_r == ST_SCAN) && (issue_r != count_r);
  assign done   = (state_r == ST_SCAN) && !rd_en && !s1_vld_r && !s2_vld_r && !s3_vld_r
                  && !sq_busy;
  assign full   = (count_r == CW'(CAPACITY));

  // coordinate bits above COORD_BITS are dropped
  assign in_x_wide = {{(COORD_WIDE_W-COORD_W){1'b0}}, in_data.center_x};
  assign in_y_wide = {{(COORD_WIDE_W-COORD_W){1'b0}}, in_data.center_y};
  assign in_x      = in_x_wide[C-1:0];
  assign in_y      = in_y_wide[C-1:0];

  assign rd_x   = rd_data_r[MW-1 -: C];
  assign rd_y   = rd_data_r[RADIUS_W +: C];
  assign rd_rad = rd_data_r[RADIUS_W-1:0];

  assign dist_sq = {2'b00, sqx_r} + {2'b00, sqy_r};

  assign fit = $signed({{(FW-RB){1'b0}}, sq_root})
             - $signed({{(FW-RADIUS_W){sq_tag[RADIUS_W-1]}}, sq_tag});

  always_comb begin
    if (best_r > LIM_HI) begin
      best_clamped = LIM_HI;
    end else if (best_r < LIM_LO) begin
      best_clamped = LIM_LO;
    end else begin
      best_clamped = best_r;
    end
  end
  assign radius_out = best_clamped[RADIUS_W-1:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (done) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      issue_r      <= '0;
      max_radius_r <= MAX_RADIUS_RESET;
      out_valid_r  <= 1'b0;
      s1_vld_r     <= 1'b0;
      s2_vld_r     <= 1'b0;
      s3_vld_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= done;
      s1_vld_r    <= rd_en;
      s2_vld_r    <= s1_vld_r;
      s3_vld_r    <= s2_vld_r;
      if (cfg_valid && cfg_ready) max_radius_r <= cfg_data;
      if (accept) begin
        issue_r <= '0;
      end else if (rd_en) begin
        issue_r <= issue_r + CW'(1);
      end
      if (done && !full) count_r <= count_r + CW'(1);
    end
  end

  // circle store: read while scanning, written once when the item finishes unless the store is full
  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= mem[issue_r[AW-1:0]];
    if (done && !full) mem[count_r[AW-1:0]] <= {cx_r, cy_r, radius_out};
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cx_r   <= in_x;
      cy_r   <= in_y;
      best_r <= $signed({{(FW-MAXR_W){1'b0}}, max_radius_r});
    end else if (sq_vld && (fit < best_r)) begin
      best_r <= fit;
    end
    dx_r   <= (cx_r > rd_x) ? cx_r - rd_x : rd_x - cx_r;
    dy_r   <= (cy_r > rd_y) ? cy_r - rd_y : rd_y - cy_r;
    rad2_r <= rd_rad;
    sqx_r  <= dx_r * dx_r;
    sqy_r  <= dy_r * dy_r;
    rad3_r <= rad2_r;
    if (done) begin
      out_data_r.radius     <= radius_out;
      out_data_r.store_full <= full;
    end
  end

  cpr_isqrt #(
    .RB    (RB),
    .TAG_W (RADIUS_W)
  ) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s3_vld_r),
    .in_value  (dist_sq),
    .in_tag    (rad3_r),
    .out_valid (sq_vld),
    .out_root  (sq_root),
    .out_tag   (sq_tag),
    .pipe_busy (sq_busy)
  );

  assign busy      = (state_r == ST_SCAN);
  assign cfg_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hdl/cpr_checker.sv =====
`include "circle_packing_radius_defines.svh"

module cpr_checker
  import cpr_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input out_item_t out_data
);

  // accepted transaction keeps the block busy in the following cycle
  `CPR_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy not raised after accept")

  // one cycle strobe per result
  `CPR_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid, "result strobe longer than one cycle")

  // a result only follows a busy period
  `CPR_ASSERT_NOW(a_result_after_busy, out_valid, $past(busy), "result without prior work")

  // radius is clamped to the symmetric range
  `CPR_ASSERT_NOW(a_radius_range, out_valid, out_data.radius != 11'h400, "radius out of range")

endmodule

bind circle_packing_radius cpr_checker u_cpr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
